/* rtl/bdar_pkg.sv */
package bdar_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;

    localparam logic [IDX_W-1:0] REG_DEBOUNCE      = 2'd0;
    localparam logic [IDX_W-1:0] REG_INITIAL_DELAY = 2'd1;
    localparam logic [IDX_W-1:0] REG_FIRST_IVL     = 2'd2;
    localparam logic [IDX_W-1:0] REG_MIN_IVL       = 2'd3;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST      = 16'd10;
    localparam logic [CFG_W-1:0] INITIAL_DELAY_RST = 16'd500;
    localparam logic [CFG_W-1:0] FIRST_IVL_RST     = 16'd450;
    localparam logic [CFG_W-1:0] MIN_IVL_RST       = 16'd5;

    // round(0.8 * 2^16), exact floor of 8/10 for every 16-bit interval
    localparam logic [CFG_W-1:0] SHRINK_MULT = 16'd52429;

    typedef struct packed {
        logic [CFG_W-1:0] settle_ms;
        logic [CFG_W-1:0] initial_delay_ms;
        logic [CFG_W-1:0] first_interval_ms;
        logic [CFG_W-1:0] min_interval_ms;
    } bdar_cfg_t;

    typedef struct packed {
        logic              previous_raw;
        logic              stable_level;
        logic              held_flag;
        logic [TIME_W-1:0] change_time;
        logic [TIME_W-1:0] press_time;
        logic [TIME_W-1:0] last_fire_time;
        logic [CFG_W-1:0]  current_interval;
    } bdar_state_t;

endpackage

/* rtl/bdar_shrink.sv */
module bdar_shrink
    import bdar_pkg::*;
(
    input  logic [CFG_W-1:0] interval,
    input  logic [CFG_W-1:0] min_interval,
    output logic [CFG_W-1:0] shrunk
);

    logic [2*CFG_W-1:0] product;
    logic [CFG_W-1:0]   scaled;

    assign product = interval * SHRINK_MULT;
    assign scaled  = product[2*CFG_W-1:CFG_W];

    always_comb begin
        if (interval <= min_interval) begin
            shrunk = interval;
        end else if (scaled < min_interval) begin
            shrunk = min_interval;
        end else begin
            shrunk = scaled;
        end
    end

endmodule

/* rtl/bdar_core.sv */
module bdar_core
    import bdar_pkg::*;
(
    input  bdar_cfg_t         cfg,
    input  bdar_state_t       state,
    input  logic              raw_level,
    input  logic [TIME_W-1:0] now_ms,
    output bdar_state_t       state_next,
    output logic              key_event
);

    logic [CFG_W-1:0]  shrunk;
    logic [TIME_W-1:0] change_t;
    logic              stable_n;
    logic              repeat_due;

    bdar_shrink u_shrink (
        .interval     (state.current_interval),
        .min_interval (cfg.min_interval_ms),
        .shrunk       (shrunk)
    );

    assign change_t = (raw_level != state.previous_raw) ? now_ms : state.change_time;
    assign stable_n = ((now_ms - change_t) >= {{(TIME_W-CFG_W){1'b0}}, cfg.settle_ms})
                    ? raw_level : state.stable_level;
    assign repeat_due =
        ((now_ms - state.press_time) >= {{(TIME_W-CFG_W){1'b0}}, cfg.initial_delay_ms}) &&
        ((now_ms - state.last_fire_time) >=
         {{(TIME_W-CFG_W){1'b0}}, state.current_interval});

    always_comb begin
        state_next              = state;
        state_next.previous_raw = raw_level;
        state_next.change_time  = change_t;
        state_next.stable_level = stable_n;
        key_event               = 1'b0;
        if (!stable_n) begin
            if (!state.held_flag) begin
                state_next.held_flag        = 1'b1;
                state_next.press_time       = now_ms;
                state_next.last_fire_time   = now_ms;
                state_next.current_interval = cfg.first_interval_ms;
                key_event                   = 1'b1;
            end else if (repeat_due) begin
                state_next.last_fire_time   = now_ms;
                state_next.current_interval = shrunk;
                key_event                   = 1'b1;
            end
        end else begin
            state_next.held_flag = 1'b0;
        end
    end

endmodule

/* rtl/button_debounce_accel_repeat.sv */
// s_ requests are registered in the input stage, results in the m_ output stage.
// Throughput: one request per cycle unless m_tready stalls; the whole state update
// is one pass of compare and select logic plus a 16x16 constant multiply.
// Reset: aresetn is synchronous and active low; it empties both stages,
// restores the register defaults and returns the button to released.
module button_debounce_accel_repeat
    import bdar_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [0] raw_level, [32:1] now_ms, rest zero
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [0] key_event, rest zero
    input  logic                cfg_wr_en,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    bdar_cfg_t         cfg_reg;
    bdar_state_t       state_reg;
    bdar_state_t       state_next;
    logic              in_valid_reg;
    logic              in_raw_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic              out_valid_reg;
    logic              out_event_reg;
    logic              event_next;
    logic              advance;
    logic              fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-1){1'b0}}, out_event_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.settle_ms         <= DEBOUNCE_RST;
            cfg_reg.initial_delay_ms  <= INITIAL_DELAY_RST;
            cfg_reg.first_interval_ms <= FIRST_IVL_RST;
            cfg_reg.min_interval_ms   <= MIN_IVL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DEBOUNCE:      cfg_reg.settle_ms         <= cfg_wdata;
                REG_INITIAL_DELAY: cfg_reg.initial_delay_ms  <= cfg_wdata;
                REG_FIRST_IVL:     cfg_reg.first_interval_ms <= cfg_wdata;
                REG_MIN_IVL:       cfg_reg.min_interval_ms   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_raw_reg <= s_tdata[0];
            in_now_reg <= s_tdata[TIME_W:1];
        end
    end

    bdar_core u_core (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .raw_level  (in_raw_reg),
        .now_ms     (in_now_reg),
        .state_next (state_next),
        .key_event  (event_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.previous_raw     <= 1'b1;
            state_reg.stable_level     <= 1'b1;
            state_reg.held_flag        <= 1'b0;
            state_reg.change_time      <= '0;
            state_reg.press_time       <= '0;
            state_reg.last_fire_time   <= '0;
            state_reg.current_interval <= FIRST_IVL_RST;
            out_valid_reg              <= 1'b0;
        end else begin
            if (fire) begin
                state_reg <= state_next;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
        if (fire) begin
            out_event_reg <= event_next;
        end
    end

`ifndef SYNTHESIS
    a_held_means_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.held_flag |-> !state_reg.stable_level)
        else $error("held flag set while stable level is released");

    a_press_emits_event: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg.held_flag) |-> (out_valid_reg && out_event_reg))
        else $error("new press did not emit an event");

    a_state_moves_on_request: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(state_reg) |-> $past(fire))
        else $error("state changed without a request");

    a_output_from_request: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(fire))
        else $error("result appeared without a request");
`endif

endmodule
